[hw/rtl/dfa_pkg.sv]
// Shared types and codes for the table-driven DFA matcher.
// Used by dfa_front, dfa_exec and the top level; depends on nothing else.
`default_nettype none

package dfa_pkg;

  localparam int STATE_W = 4;
  localparam int SYM_W   = 4;
  localparam int MASK_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_EMPTY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_STATE = 2'd0,
    REG_ACCEPT_MASK   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  // One word on the input channel.
  typedef struct packed {
    logic [1:0]         command;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] row_state;
    logic [STATE_W-1:0] entry_next;
    logic               entry_dead;
    logic               last;
  } item_t;

  // One word on the result channel.
  typedef struct packed {
    logic               accepted;
    logic [STATE_W-1:0] end_state;
    logic               died;
  } result_t;

  // One transition table entry.
  typedef struct packed {
    logic               dead;
    logic [STATE_W-1:0] next;
  } entry_t;

  // Classified word passed from front to execution.
  typedef struct packed {
    op_t                op;
    logic               sym_ok;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] row_state;
    entry_t             entry;
    logic               last;
  } op_item_t;

endpackage

`default_nettype wire

[hw/rtl/dfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the transition table.
`default_nettype none

module dfa_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dfa_fifo.sv]
// Small register FIFO used for the command queue and the result queue.
// No dependencies.
`default_nettype none

module dfa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  output logic      [WIDTH-1:0]           rd_data,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count_next;
  logic             do_wr, do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = store[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_wr) begin
      wr_ptr_next = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_next = count + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dfa_front.sv]
// Front end: takes input words, decodes the command and range-checks the
// table coordinates. Depends on dfa_pkg.
`default_nettype none

module dfa_front #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  wire logic             push,
  input  wire dfa_pkg::item_t   item,
  input  wire logic             q_full,
  output logic                  full,
  output logic                  q_push,
  output dfa_pkg::op_item_t     q_item
);

  import dfa_pkg::*;

  logic sym_ok, row_ok, keep;

  assign sym_ok = 32'(item.symbol) < 32'(NUM_SYMBOLS);
  assign row_ok = 32'(item.row_state) < 32'(NUM_STATES);
  assign full   = q_full;

  always_comb begin
    q_item.sym_ok     = sym_ok;
    q_item.symbol     = item.symbol;
    q_item.row_state  = item.row_state;
    q_item.entry.dead = item.entry_dead;
    q_item.entry.next = item.entry_next;
    q_item.last       = item.last;
    q_item.op         = OP_STEP;
    keep              = 1'b0;
    case (cmd_t'(item.command))
      CMD_WRITE: begin
        // drop writes outside the table
        q_item.op = OP_WRITE;
        keep      = sym_ok && row_ok;
      end
      CMD_STEP: begin
        q_item.op = OP_STEP;
        keep      = 1'b1;
      end
      CMD_EMPTY: begin
        q_item.op = OP_EMPTY;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = push && !q_full && keep;

endmodule

`default_nettype wire

[hw/rtl/dfa_exec.sv]
// Back end: runs table writes and symbol steps against the table RAM,
// resolves each read in the cycle after it issues and emits results. Depends on dfa_pkg.
`default_nettype none

module dfa_exec #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16,
  parameter int OUT_DEPTH   = 4
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          cfg_valid,
  output logic                                               cfg_ready,
  input  wire logic [dfa_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  wire logic [dfa_pkg::CFG_DATA_W-1:0]                cfg_data,
  input  wire logic                                          q_empty,
  input  wire dfa_pkg::op_item_t                             q_item,
  output logic                                               q_pop,
  output logic                                               ram_we,
  output logic [$clog2(NUM_STATES*NUM_SYMBOLS)-1:0]          ram_waddr,
  output dfa_pkg::entry_t                                    ram_wdata,
  output logic                                               ram_re,
  output logic [$clog2(NUM_STATES*NUM_SYMBOLS)-1:0]          ram_raddr,
  input  wire dfa_pkg::entry_t                               ram_rdata,
  output logic                                               res_push,
  output dfa_pkg::result_t                                   res_item,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]                res_count
);

  import dfa_pkg::*;

  localparam int ADDR_W = $clog2(NUM_STATES * NUM_SYMBOLS);
  localparam logic [ADDR_W-1:0] SYM_MULT = ADDR_W'(NUM_SYMBOLS);

  logic [STATE_W-1:0] initial_state;
  logic [MASK_W-1:0]  accept_mask;
  logic [STATE_W-1:0] cur_state;
  logic               cur_dead;

  // resolve stage: holds the step whose table read is in flight
  logic               r_valid;
  logic               r_read;
  logic [STATE_W-1:0] r_state;
  logic               r_dead;
  logic               r_last;
  logic               r_empty;

  logic [STATE_W-1:0] res_state, live_state;
  logic               res_dead, live_dead, r_result;
  logic               issue_ok, cfg_wr, step_oor, is_step;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign res_dead  = r_read ? ram_rdata.dead : r_dead;
  assign res_state = (r_read && !ram_rdata.dead) ? ram_rdata.next : r_state;
  assign r_result  = r_valid && (r_last || r_empty);

  always_comb begin
    res_item = '0;
    if (r_empty) begin
      res_item.accepted  = (32'(initial_state) < 32'(NUM_STATES)) &&
                           accept_mask[initial_state];
      res_item.end_state = initial_state;
      res_item.died      = 1'b0;
    end else if (res_dead) begin
      res_item.accepted  = 1'b0;
      res_item.end_state = '0;
      res_item.died      = 1'b1;
    end else begin
      res_item.accepted  = (32'(res_state) < 32'(NUM_STATES)) && accept_mask[res_state];
      res_item.end_state = res_state;
      res_item.died      = 1'b0;
    end
  end

  assign res_push = r_result;

  // state seen by the word issuing this cycle; restart after a string end
  always_comb begin
    if (r_result) begin
      live_state = initial_state;
      live_dead  = 1'b0;
    end else if (r_valid) begin
      live_state = res_state;
      live_dead  = res_dead;
    end else begin
      live_state = cur_state;
      live_dead  = cur_dead;
    end
  end

  // leave a slot for the result still in the resolve stage
  assign issue_ok = (32'(res_count) + 32'(r_result)) < 32'(OUT_DEPTH);
  assign q_pop    = !q_empty && issue_ok;

  assign is_step  = (q_item.op == OP_STEP);
  assign step_oor = !q_item.sym_ok || (32'(live_state) >= 32'(NUM_STATES));

  assign ram_we    = q_pop && (q_item.op == OP_WRITE);
  assign ram_waddr = ADDR_W'(q_item.row_state) * SYM_MULT + ADDR_W'(q_item.symbol);
  assign ram_wdata = q_item.entry;
  assign ram_re    = q_pop && is_step && !live_dead && !step_oor;
  assign ram_raddr = ADDR_W'(live_state) * SYM_MULT + ADDR_W'(q_item.symbol);

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_state <= '0;
      accept_mask   <= '0;
      cur_state     <= '0;
      cur_dead      <= 1'b0;
      r_valid       <= 1'b0;
      r_read        <= 1'b0;
      r_last        <= 1'b0;
      r_empty       <= 1'b0;
    end else begin
      r_valid   <= q_pop;
      r_read    <= ram_re;
      r_last    <= q_pop && is_step && q_item.last;
      r_empty   <= q_pop && (q_item.op == OP_EMPTY);
      // a new initial state restarts the open string
      if (cfg_wr && (cfg_reg_t'(cfg_index) == REG_INITIAL_STATE)) begin
        cur_state <= cfg_data[STATE_W-1:0];
        cur_dead  <= 1'b0;
      end else begin
        cur_state <= live_state;
        cur_dead  <= live_dead;
      end
      if (cfg_wr) begin
        case (cfg_reg_t'(cfg_index))
          REG_INITIAL_STATE: begin
            initial_state <= cfg_data[STATE_W-1:0];
          end
          REG_ACCEPT_MASK: begin
            accept_mask <= cfg_data[MASK_W-1:0];
          end
          default: begin
            accept_mask <= accept_mask;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    r_state <= live_state;
    r_dead  <= live_dead || (q_pop && is_step && step_oor);
  end

endmodule

`default_nettype wire

[hw/rtl/table_driven_dfa_matcher.sv]
// Top level of the table-driven DFA matcher: front end, command queue,
// execution stage, transition table RAM and result queue. Depends on dfa_pkg.
//
// Usage:
//   Input words enter like a queue write: push with full low. Command 0
//   writes one transition table entry, command 1 steps one symbol, command 2
//   classifies the empty string. A step flagged last, and every empty-string
//   command, yield one result; results leave like a queue read: the oldest
//   sits on result while empty is low and goes on pop.
//   The config channel (cfg_valid/cfg_ready, always ready) sets
//   initial_state (index 0) and accept_mask (index 1); write it only while
//   no word is in flight. Writing initial_state restarts the current string.
//   Each word's result goes through the resolve stage into the result queue.
//   Throughput is one word per cycle while the result queue has room: the
//   table RAM has a registered read, and its read data feeds the next step's
//   address in the following cycle. When pop stays low the result queue
//   fills, the execution stage holds, then the command queue fills and full rises.
//   Reset clears the queues, the run state and both config registers; the
//   table holds garbage until written, so load it before stepping.
`default_nettype none

module table_driven_dfa_matcher #(
  parameter int NUM_STATES   = 16,
  parameter int NUM_SYMBOLS  = 16,
  parameter int QUEUE_DEPTH  = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire dfa_pkg::item_t                    item,
  output logic                                   empty,
  input  wire logic                              pop,
  output dfa_pkg::result_t                       result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import dfa_pkg::*;

  localparam int ADDR_W  = $clog2(NUM_STATES * NUM_SYMBOLS);
  localparam int OP_W    = $bits(op_item_t);
  localparam int RES_W   = $bits(result_t);
  localparam int ENTRY_W = $bits(entry_t);

  logic                             q_full, q_empty, q_push, q_pop;
  op_item_t                         q_wr_item, q_rd_item;
  logic [OP_W-1:0]                  q_rd_bits;
  logic                             ram_we, ram_re;
  logic [ADDR_W-1:0]                ram_waddr, ram_raddr;
  entry_t                           ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]               ram_rbits;
  logic                             res_push, res_full;
  result_t                          res_item;
  logic [RES_W-1:0]                 res_bits;
  logic [$clog2(RESULT_DEPTH+1)-1:0] res_count;

  dfa_front #(
    .NUM_STATES (NUM_STATES),
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_front (
    .push  (push),
    .item  (item),
    .q_full(q_full),
    .full  (full),
    .q_push(q_push),
    .q_item(q_wr_item)
  );

  dfa_fifo #(
    .WIDTH(OP_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(q_wr_item),
    .rd_en  (q_pop),
    .rd_data(q_rd_bits),
    .full   (q_full),
    .empty  (q_empty),
    .count  ()
  );

  assign q_rd_item = op_item_t'(q_rd_bits);

  dfa_exec #(
    .NUM_STATES (NUM_STATES),
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .OUT_DEPTH  (RESULT_DEPTH)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_item   (q_rd_item),
    .q_pop    (q_pop),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res_push (res_push),
    .res_item (res_item),
    .res_count(res_count)
  );

  dfa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_STATES * NUM_SYMBOLS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  // exec only pushes when a slot is reserved, so res_full is never hit
  dfa_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RESULT_DEPTH)
  ) u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push && !res_full),
    .wr_data(res_item),
    .rd_en  (pop),
    .rd_data(res_bits),
    .full   (res_full),
    .empty  (empty),
    .count  (res_count)
  );

  assign result = result_t'(res_bits);

endmodule

`default_nettype wire
